/* design/cmm_pkg.sv */
// Shared types and constants of the column-major matrix multiply block.
package cmm_pkg;

    localparam int ROW_CNT_W  = 5;
    localparam int COL_CNT_W  = 9;
    localparam int COM_CNT_W  = 5;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    localparam logic [ROW_CNT_W-1:0] ROW_CNT_RESET = 5'd16;
    localparam logic [COL_CNT_W-1:0] COL_CNT_RESET = 9'd16;
    localparam logic [COM_CNT_W-1:0] COM_CNT_RESET = 5'd16;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMMON_COUNT = 2'd2;

    localparam int PRODUCT_W = 36;
    localparam int ROW_IDX_W = 4;
    localparam int COL_IDX_W = 8;
    localparam int M_DATA_W  = PRODUCT_W + ROW_IDX_W + COL_IDX_W;

    typedef enum logic [2:0] {
        ST_LOAD_A,
        ST_WAIT_B,
        ST_MAC,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_EMIT
    } cmm_state_t;

    typedef struct packed {
        logic a_we;          // write the incoming element into the A store
        logic load_elem;     // capture the incoming B element
        logic mac_issue;     // start one multiply-accumulate for row_idx
        logic mac_first;     // first inner step: overwrite the accumulator
        logic emit_load;     // load the result of row_idx into the output register
        logic emit_last_col;
        logic emit_last_mat;
    } cmm_cmd_t;

endpackage

/* design/cmm_ctrl.sv */
// Sequencer of the matrix multiply: configuration, counters and command issue.
module cmm_ctrl
    import cmm_pkg::*;
#(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COMMON = 16,
    parameter int MAX_COLS   = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  out_free,
    output cmm_cmd_t              cmd,
    output logic [((MAX_ROWS*MAX_COMMON > 1) ? $clog2(MAX_ROWS*MAX_COMMON) : 1)-1:0] a_addr,
    output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] row_idx,
    output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] col_idx
);

    localparam int A_DEPTH = MAX_ROWS * MAX_COMMON;
    localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
    localparam int R_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int C_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int K_W     = (MAX_COMMON > 1) ? $clog2(MAX_COMMON) : 1;
    localparam int ROW_W   = $clog2(MAX_ROWS + 1);
    localparam int COM_W   = $clog2(MAX_COMMON + 1);
    localparam int COLS_W  = $clog2(MAX_COLS + 1);
    localparam int FILL_W  = ROW_W + COM_W;

    cmm_state_t             state_reg, state_next;
    logic [ROW_CNT_W-1:0]   row_cnt_reg, row_cnt_next;
    logic [COL_CNT_W-1:0]   col_cnt_reg, col_cnt_next;
    logic [COM_CNT_W-1:0]   com_cnt_reg, com_cnt_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [K_W-1:0]         inner_reg, inner_next;
    logic [A_AW-1:0]        base_reg, base_next;
    logic [R_W-1:0]         row_reg, row_next;
    logic [C_W-1:0]         col_reg, col_next;

    logic [ROW_W-1:0]  rows_eff;
    logic [COM_W-1:0]  common_eff;
    logic [COLS_W-1:0] cols_eff;
    logic [FILL_W-1:0] a_total;
    logic              last_row, last_inner, last_col, a_full;
    logic              cfg_restart;

    // Zero acts as one, anything above the bound acts as the bound.
    assign rows_eff = (row_cnt_reg == '0) ? ROW_W'(1) :
                      (32'(row_cnt_reg) > 32'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) :
                      ROW_W'(row_cnt_reg);
    assign common_eff = (com_cnt_reg == '0) ? COM_W'(1) :
                        (32'(com_cnt_reg) > 32'(MAX_COMMON)) ? COM_W'(MAX_COMMON) :
                        COM_W'(com_cnt_reg);
    assign cols_eff = (col_cnt_reg == '0) ? COLS_W'(1) :
                      (32'(col_cnt_reg) > 32'(MAX_COLS)) ? COLS_W'(MAX_COLS) :
                      COLS_W'(col_cnt_reg);

    assign a_total    = {{COM_W{1'b0}}, rows_eff} * {{ROW_W{1'b0}}, common_eff};
    assign a_full     = (fill_reg + FILL_W'(1)) >= a_total;
    assign last_row   = (ROW_W'(row_reg) + ROW_W'(1)) == rows_eff;
    assign last_inner = (COM_W'(inner_reg) + COM_W'(1)) == common_eff;
    assign last_col   = (COLS_W'(col_reg) + COLS_W'(1)) == cols_eff;

    assign a_addr  = (state_reg == ST_LOAD_A) ? A_AW'(fill_reg) : base_reg + A_AW'(row_reg);
    assign row_idx = row_reg;
    assign col_idx = col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD_A;
            row_cnt_reg <= ROW_CNT_RESET;
            col_cnt_reg <= COL_CNT_RESET;
            com_cnt_reg <= COM_CNT_RESET;
            fill_reg    <= '0;
            inner_reg   <= '0;
            base_reg    <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
            com_cnt_reg <= com_cnt_next;
            fill_reg    <= fill_next;
            inner_reg   <= inner_next;
            base_reg    <= base_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        row_cnt_next = row_cnt_reg;
        col_cnt_next = col_cnt_reg;
        com_cnt_next = com_cnt_reg;
        fill_next    = fill_reg;
        inner_next   = inner_reg;
        base_next    = base_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cfg_restart  = 1'b0;

        unique case (state_reg)
            ST_LOAD_A: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.a_we = 1'b1;
                    if (a_full) begin
                        fill_next  = '0;
                        inner_next = '0;
                        base_next  = '0;
                        row_next   = '0;
                        col_next   = '0;
                        state_next = ST_WAIT_B;
                    end else begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
            end
            ST_WAIT_B: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_elem = 1'b1;
                    row_next      = '0;
                    state_next    = ST_MAC;
                end
            end
            ST_MAC: begin
                cmd.mac_issue = 1'b1;
                cmd.mac_first = (inner_reg == '0);
                if (last_row) begin
                    row_next = '0;
                    if (last_inner) begin
                        inner_next = '0;
                        base_next  = '0;
                        state_next = ST_DRAIN1;
                    end else begin
                        inner_next = inner_reg + K_W'(1);
                        base_next  = base_reg + A_AW'(rows_eff);
                        state_next = ST_WAIT_B;
                    end
                end else begin
                    row_next = row_reg + R_W'(1);
                end
            end
            // let the last accumulator writes land before the readout
            ST_DRAIN1: state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    cmd.emit_load     = 1'b1;
                    cmd.emit_last_col = last_row;
                    cmd.emit_last_mat = last_row && last_col;
                    if (last_row) begin
                        row_next = '0;
                        if (last_col) begin
                            col_next   = '0;
                            fill_next  = '0;
                            state_next = ST_LOAD_A;
                        end else begin
                            col_next   = col_reg + C_W'(1);
                            state_next = ST_WAIT_B;
                        end
                    end else begin
                        row_next = row_reg + R_W'(1);
                    end
                end
            end
            default: state_next = ST_LOAD_A;
        endcase

        // a write to any count register restarts the stream; the A store keeps its contents
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_ROW_COUNT: begin
                    row_cnt_next = cfg_wr_data[ROW_CNT_W-1:0];
                    cfg_restart  = 1'b1;
                end
                REG_COL_COUNT: begin
                    col_cnt_next = cfg_wr_data[COL_CNT_W-1:0];
                    cfg_restart  = 1'b1;
                end
                REG_COMMON_COUNT: begin
                    com_cnt_next = cfg_wr_data[COM_CNT_W-1:0];
                    cfg_restart  = 1'b1;
                end
                default: ;
            endcase
            if (cfg_restart) begin
                state_next = ST_LOAD_A;
                fill_next  = '0;
                inner_next = '0;
                base_next  = '0;
                row_next   = '0;
                col_next   = '0;
            end
        end
    end

    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_load |-> out_free)
        else $error("result loaded while output register is occupied");

    a_drain_before_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mac_issue |=> !cmd.emit_load)
        else $error("readout started without draining the MAC pipeline");

    a_load_not_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.a_we |=> !cmd.mac_issue)
        else $error("MAC issued directly after an A store write");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mac_issue || cmd.emit_load) |-> (ROW_W'(row_reg) < rows_eff))
        else $error("row counter beyond the active row count");

endmodule

/* design/cmm_datapath.sv */
// Datapath of the matrix multiply: A store, shared MAC, accumulators, output register.
module cmm_datapath
    import cmm_pkg::*;
#(
    parameter int MAX_ROWS     = 16,
    parameter int MAX_COMMON   = 16,
    parameter int MAX_COLS     = 256,
    parameter int ELEMENT_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  cmm_cmd_t                       cmd,
    input  logic signed [ELEMENT_BITS-1:0] elem,
    input  logic [((MAX_ROWS*MAX_COMMON > 1) ? $clog2(MAX_ROWS*MAX_COMMON) : 1)-1:0] a_addr,
    input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] row_idx,
    input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] col_idx,
    output logic                           out_free,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [M_DATA_W-1:0]            m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser
);

    localparam int A_DEPTH = MAX_ROWS * MAX_COMMON;
    localparam int R_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int PROD_W  = 2 * ELEMENT_BITS;
    localparam int PX_W    = PROD_W + PRODUCT_W;

    logic signed [ELEMENT_BITS-1:0] a_mem [A_DEPTH];
    logic signed [ELEMENT_BITS-1:0] a_q_reg;
    logic signed [ELEMENT_BITS-1:0] e_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [PRODUCT_W-1:0]    acc_reg [MAX_ROWS];

    logic           v1_reg, v2_reg, first1_reg, first2_reg;
    logic [R_W-1:0] r1_reg, r2_reg;

    logic [PX_W-1:0]      prod_x;
    logic [R_W-1:0]       acc_idx;
    logic [PRODUCT_W-1:0] acc_rd, acc_sum;

    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic                out_last_reg, out_user_reg;

    always_ff @(posedge aclk) begin
        if (cmd.a_we) begin
            a_mem[a_addr] <= elem;
        end
        a_q_reg <= a_mem[a_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_elem) begin
            e_reg <= elem;
        end
        prod_reg <= a_q_reg * e_reg;
        r1_reg   <= row_idx;
        r2_reg   <= r1_reg;
        first1_reg <= cmd.mac_first;
        first2_reg <= first1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.mac_issue;
            v2_reg <= v1_reg;
        end
    end

    // Only the low product bits matter: the result field wraps at its width.
    assign prod_x  = {{PRODUCT_W{prod_reg[PROD_W-1]}}, prod_reg};
    assign acc_idx = cmd.emit_load ? row_idx : r2_reg;
    assign acc_rd  = acc_reg[acc_idx];
    assign acc_sum = (first2_reg ? '0 : acc_rd) + prod_x[PRODUCT_W-1:0];

    always_ff @(posedge aclk) begin
        if (v2_reg) begin
            acc_reg[r2_reg] <= acc_sum;
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            out_data_reg <= {COL_IDX_W'(col_idx), ROW_IDX_W'(row_idx), acc_rd};
            out_last_reg <= cmd.emit_last_col;
            out_user_reg <= cmd.emit_last_mat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_load |=> m_tvalid)
        else $error("loaded result not presented");

    a_mac_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mac_issue |=> ##1 v2_reg)
        else $error("MAC pipeline lost an issue");

    a_no_emit_during_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_load |-> !v2_reg)
        else $error("readout overlaps an accumulator write");

endmodule

/* design/column_major_matrix_multiply.sv */
// Top level of the column-major matrix multiply C = A x B.
//
// One input stream (s_) carries elements: first row_count*common_count
// elements of A in column-major order, then B column by column. Results
// leave on the m_ stream, row_count beats per B column, in row order.
// m_tlast marks the last row of a column, m_tuser the last beat of the product.
// s_tready stays high while A loads. Each B element is accepted, then goes
// once per row through the single shared multiply-accumulate, which reads
// the A store at one address a cycle; no element is taken until all rows are done.
// After the last element of a column, states ST_DRAIN1 and ST_DRAIN2 drain the
// MAC pipeline, then one result a cycle is loaded into the output register; a
// stalled receiver holds the readout, and the block accepts the next element while
// the final result of a column still waits in the output register.
// The configuration port takes one register write per cycle; any write to a
// count register restarts the stream at the A load. Reset restores 16 x 16 x 16
// sizes and waits for A. The A store is not cleared and must be loaded before B.
module column_major_matrix_multiply
    import cmm_pkg::*;
#(
    parameter int MAX_ROWS     = 16,
    parameter int MAX_COMMON   = 16,
    parameter int MAX_COLS     = 256,
    parameter int ELEMENT_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [((ELEMENT_BITS+7)/8)*8-1:0] s_tdata,  // element
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,  // product_value, row_index, column_index
    output logic                  m_tlast,  // last_of_column
    output logic                  m_tuser   // last_of_matrix
);

    localparam int A_DEPTH = MAX_ROWS * MAX_COMMON;
    localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
    localparam int R_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int C_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    cmm_cmd_t        cmd;
    logic            out_free;
    logic [A_AW-1:0] a_addr;
    logic [R_W-1:0]  row_idx;
    logic [C_W-1:0]  col_idx;

    cmm_ctrl #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COMMON (MAX_COMMON),
        .MAX_COLS   (MAX_COLS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .out_free     (out_free),
        .cmd          (cmd),
        .a_addr       (a_addr),
        .row_idx      (row_idx),
        .col_idx      (col_idx)
    );

    cmm_datapath #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_COMMON   (MAX_COMMON),
        .MAX_COLS     (MAX_COLS),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .elem     (s_tdata[ELEMENT_BITS-1:0]),
        .a_addr   (a_addr),
        .row_idx  (row_idx),
        .col_idx  (col_idx),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
